[rtl/core/cmdp_pkg.sv]
// ----------------------------------------------------------------------------
// Command parser package
// Shared widths, keyword tables, parser state and result types.
// ----------------------------------------------------------------------------
package cmdp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned NumW   = 31;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CountW = 3;
  localparam int unsigned NumKw  = 5;

  localparam logic [NumW-1:0]  SatMax    = '1;
  localparam logic [CharW-1:0] SpaceChar = 8'd32;
  localparam logic [CharW-1:0] DigitLo   = "0";
  localparam logic [CharW-1:0] DigitHi   = "9";

  typedef enum logic [CodeW-1:0] {
    CmdAdd   = 3'd0,
    CmdRm    = 3'd1,
    CmdQuery = 3'd2,
    CmdList  = 3'd3,
    CmdKill  = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CountW-1:0] tok_cnt;
    logic              in_tok;
    logic [CountW-1:0] kw_pos;
    logic [NumKw-1:0]  kw_cand;
    logic              x_digits;
    logic              y_digits;
    logic [NumW-1:0]   x_acc;
    logic [NumW-1:0]   y_acc;
  } state_t;

  localparam state_t StateRst = '{
    tok_cnt:  '0,
    in_tok:   1'b0,
    kw_pos:   '0,
    kw_cand:  '1,
    x_digits: 1'b1,
    y_digits: 1'b1,
    x_acc:    '0,
    y_acc:    '0
  };

  typedef struct packed {
    logic            valid_res;
    cmd_e            cmd_code;
    logic [NumW-1:0] x_value;
    logic [NumW-1:0] y_value;
  } result_t;

  function automatic logic [CountW-1:0] kw_len(input cmd_e k);
    logic [CountW-1:0] len;
    case (k)
      CmdAdd:   len = 3'd3;
      CmdRm:    len = 3'd2;
      CmdQuery: len = 3'd5;
      CmdList:  len = 3'd4;
      CmdKill:  len = 3'd4;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [CharW-1:0] kw_char(input cmd_e k, input logic [CountW-1:0] pos);
    logic [CharW-1:0] ch;
    ch = '0;
    case (k)
      CmdAdd: begin
        case (pos)
          3'd0:    ch = "a";
          3'd1:    ch = "d";
          3'd2:    ch = "d";
          default: ch = '0;
        endcase
      end
      CmdRm: begin
        case (pos)
          3'd0:    ch = "r";
          3'd1:    ch = "m";
          default: ch = '0;
        endcase
      end
      CmdQuery: begin
        case (pos)
          3'd0:    ch = "q";
          3'd1:    ch = "u";
          3'd2:    ch = "e";
          3'd3:    ch = "r";
          3'd4:    ch = "y";
          default: ch = '0;
        endcase
      end
      CmdList: begin
        case (pos)
          3'd0:    ch = "l";
          3'd1:    ch = "i";
          3'd2:    ch = "s";
          3'd3:    ch = "t";
          default: ch = '0;
        endcase
      end
      CmdKill: begin
        case (pos)
          3'd0:    ch = "k";
          3'd1:    ch = "i";
          3'd2:    ch = "l";
          3'd3:    ch = "l";
          default: ch = '0;
        endcase
      end
      default: ch = '0;
    endcase
    return ch;
  endfunction

  function automatic logic [NumW-1:0] push_digit(input logic [NumW-1:0] acc,
                                                 input logic [3:0] digit);
    logic [NumW+3:0] wide;
    logic [NumW-1:0] res;
    wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NumW+4)'(digit);
    if (wide > (NumW+4)'(SatMax)) begin
      res = SatMax;
    end else begin
      res = wide[NumW-1:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/cmdp_stream_if.sv]
// ----------------------------------------------------------------------------
// Command parser channels
// Valid/ready channels for message bytes and parse results.
// ----------------------------------------------------------------------------
interface cmdp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [cmdp_pkg::CharW-1:0]  char_in;
  logic                        end_of_message;

  modport source (output valid, output char_in, output end_of_message, input ready);
  modport sink (input valid, input char_in, input end_of_message, output ready);
endinterface

interface cmdp_result_if;
  logic                        valid;
  logic                        ready;
  logic                        valid_res;
  logic [cmdp_pkg::CodeW-1:0]  cmd_code;
  logic [cmdp_pkg::NumW-1:0]   x_value;
  logic [cmdp_pkg::NumW-1:0]   y_value;

  modport source (output valid, output valid_res, output cmd_code, output x_value,
                  output y_value, input ready);
  modport sink (input valid, input valid_res, input cmd_code, input x_value,
                input y_value, output ready);
endinterface

[rtl/core/cmdp_tokenizer.sv]
// ----------------------------------------------------------------------------
// Command parser tokenizer
// Holds the parse state and advances it by one message byte per step.
// ----------------------------------------------------------------------------
module cmdp_tokenizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [cmdp_pkg::CharW-1:0] char_i,
  input  logic                       last_i,
  output cmdp_pkg::state_t           state_o
);

  cmdp_pkg::state_t st_q;
  cmdp_pkg::state_t st_d;
  cmdp_pkg::state_t nxt;
  logic             is_digit;
  logic [3:0]       digit;
  logic [cmdp_pkg::CharW-1:0] digit_full;

  assign is_digit   = (char_i >= cmdp_pkg::DigitLo) && (char_i <= cmdp_pkg::DigitHi);
  assign digit_full = char_i - cmdp_pkg::DigitLo;
  assign digit      = digit_full[3:0];

  always_comb begin
    nxt = st_q;
    if (char_i == cmdp_pkg::SpaceChar) begin
      nxt.in_tok = 1'b0;
    end else begin
      if (!st_q.in_tok) begin
        nxt.in_tok = 1'b1;
        if (st_q.tok_cnt != '1) begin
          nxt.tok_cnt = st_q.tok_cnt + 3'd1;
        end
      end
      case (nxt.tok_cnt)
        3'd1: begin
          for (int k = 0; k < cmdp_pkg::NumKw; k++) begin
            if (st_q.kw_pos >= cmdp_pkg::kw_len(cmdp_pkg::cmd_e'(3'(k))) ||
                cmdp_pkg::kw_char(cmdp_pkg::cmd_e'(3'(k)), st_q.kw_pos) != char_i) begin
              nxt.kw_cand[k] = 1'b0;
            end
          end
          if (st_q.kw_pos != '1) begin
            nxt.kw_pos = st_q.kw_pos + 3'd1;
          end
        end
        3'd2: begin
          if (is_digit) begin
            nxt.x_acc = cmdp_pkg::push_digit(st_q.x_acc, digit);
          end else begin
            nxt.x_digits = 1'b0;
          end
        end
        3'd3: begin
          if (is_digit) begin
            nxt.y_acc = cmdp_pkg::push_digit(st_q.y_acc, digit);
          end else begin
            nxt.y_digits = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      st_d = last_i ? cmdp_pkg::StateRst : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cmdp_pkg::StateRst;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = nxt;

endmodule

[rtl/core/cmdp_decode.sv]
// ----------------------------------------------------------------------------
// Command parser decode
// Turns the final parse state of a message into its result item.
// ----------------------------------------------------------------------------
module cmdp_decode (
  input  cmdp_pkg::state_t  state_i,
  output cmdp_pkg::result_t result_o
);

  logic           found;
  logic           ok;
  cmdp_pkg::cmd_e code;

  always_comb begin
    found = 1'b0;
    code  = cmdp_pkg::CmdAdd;
    if (state_i.tok_cnt != '0) begin
      for (int k = 0; k < cmdp_pkg::NumKw; k++) begin
        if (!found && state_i.kw_cand[k] &&
            state_i.kw_pos == cmdp_pkg::kw_len(cmdp_pkg::cmd_e'(3'(k)))) begin
          found = 1'b1;
          code  = cmdp_pkg::cmd_e'(3'(k));
        end
      end
    end
  end

  always_comb begin
    ok = 1'b0;
    if (found) begin
      if (code == cmdp_pkg::CmdList || code == cmdp_pkg::CmdKill) begin
        ok = (state_i.tok_cnt == 3'd1);
      end else begin
        ok = (state_i.tok_cnt == 3'd3) && state_i.x_digits && state_i.y_digits;
      end
    end
  end

  always_comb begin
    result_o.valid_res = ok;
    result_o.cmd_code  = ok ? code : cmdp_pkg::CmdAdd;
    result_o.x_value   = '0;
    result_o.y_value   = '0;
    if (ok && code != cmdp_pkg::CmdList && code != cmdp_pkg::CmdKill) begin
      result_o.x_value = state_i.x_acc;
      result_o.y_value = state_i.y_acc;
    end
  end

endmodule

[rtl/core/command_message_parser_unit.sv]
// ----------------------------------------------------------------------------
// Command message parser
// Parses a text command message byte by byte into a command code and two
// numeric arguments.
// ----------------------------------------------------------------------------
// Usage: drive one message byte per item on in_i, with end_of_message set on
// the final byte. Bytes of value 32 separate tokens. Only the final byte of a
// message yields an item on res_o: a validity flag, the command code and the
// two saturated arguments. Other bytes yield nothing.
// Throughput: one byte per cycle, save that a final byte holds while the
// result register is full. Each byte is held in an input register and then
// applied to the parse state, with the multiply-by-ten of the argument
// accumulators between the input and state registers. A final byte passes
// the input register, then the result register. Reset clears the parse
// state and the valid flags of both; the state also clears after each item.
// Stall: while a result item waits on res_o, bytes that do not end a message
// still advance; a byte that ends a message holds in the input register until
// the result register frees, and in_i.ready drops behind it.
// ----------------------------------------------------------------------------
module command_message_parser_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cmdp_byte_if.sink             in_i,
  cmdp_result_if.source         res_o
);

  logic                       in_vld_q;
  logic [cmdp_pkg::CharW-1:0] in_char_q;
  logic                       in_last_q;
  logic                       advance;
  logic                       res_free;
  cmdp_pkg::state_t           fin_state;
  cmdp_pkg::result_t          res_d;
  cmdp_pkg::result_t          res_q;
  logic                       res_vld_q;

  assign res_free   = !res_vld_q || res_o.ready;
  assign advance    = in_vld_q && (!in_last_q || res_free);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_char_q <= in_i.char_in;
      in_last_q <= in_i.end_of_message;
    end
  end

  cmdp_tokenizer u_tokenizer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .state_o (fin_state)
  );

  cmdp_decode u_decode (
    .state_i  (fin_state),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= advance && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && advance && in_last_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid     = res_vld_q;
  assign res_o.valid_res = res_q.valid_res;
  assign res_o.cmd_code  = res_q.cmd_code;
  assign res_o.x_value   = res_q.x_value;
  assign res_o.y_value   = res_q.y_value;

endmodule

[test/command_message_parser_unit_test.sv]
// ----------------------------------------------------------------------------
// Command message parser testbench
// Sends whole text messages one byte per item. A parse predictor built into
// the bench tracks the token state and queues the result that is due on each
// final byte. Every result item is compared against the oldest queued result.
// Directed messages cover every keyword, saturation and the malformed forms.
// Random traffic then runs under four sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module command_message_parser_unit_test;
  import cmdp_pkg::*;

  typedef struct packed {
    logic            valid_res;
    cmd_e            code;
    logic [NumW-1:0] x_value;
    logic [NumW-1:0] y_value;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cmdp_byte_if   msg_bytes ();
  cmdp_result_if parse_res ();

  command_message_parser_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (msg_bytes),
    .res_o  (parse_res)
  );

  logic [CountW-1:0] tok_n;
  logic              in_word;
  logic [CountW-1:0] kw_idx;
  logic [NumKw-1:0]  kw_alive;
  logic              x_is_num;
  logic              y_is_num;
  logic [NumW-1:0]   x_num;
  logic [NumW-1:0]   y_num;

  parse_result_t parse_results_due [$];

  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int mismatches         = 0;
  int bytes_sent         = 0;
  int messages_sent      = 0;
  int results_checked    = 0;
  int well_formed_seen   = 0;

  function automatic string keyword_text(input cmd_e op);
    case (op)
      CmdAdd:   return "add";
      CmdRm:    return "rm";
      CmdQuery: return "query";
      CmdList:  return "list";
      CmdKill:  return "kill";
      default:  return "";
    endcase
  endfunction

  function automatic void clear_parse();
    tok_n    = '0;
    in_word  = 1'b0;
    kw_idx   = '0;
    kw_alive = '1;
    x_is_num = 1'b1;
    y_is_num = 1'b1;
    x_num    = '0;
    y_num    = '0;
  endfunction

  function automatic logic [NumW-1:0] times_ten_plus(input logic [NumW-1:0] acc,
                                                     input logic [CharW-1:0] ch);
    logic [NumW+4:0] sum;
    sum = (NumW+5)'(acc) * 10 + (NumW+5)'(ch - DigitLo);
    if (sum > (NumW+5)'(SatMax)) return SatMax;
    return sum[NumW-1:0];
  endfunction

  function automatic void predict_parse_byte(input logic [CharW-1:0] ch, input logic last);
    parse_result_t want;
    string         kw;
    logic          is_digit;
    logic          found;
    int            k;
    is_digit = (ch >= DigitLo) && (ch <= DigitHi);
    if (ch == SpaceChar) begin
      in_word = 1'b0;
    end else begin
      if (!in_word) begin
        in_word = 1'b1;
        if (tok_n != 3'd7) tok_n++;
      end
      if (tok_n == 1) begin
        for (k = 0; k < NumKw; k++) begin
          kw = keyword_text(cmd_e'(k));
          if (kw_idx >= kw.len() || kw[kw_idx] != ch) kw_alive[k] = 1'b0;
        end
        if (kw_idx != 3'd7) kw_idx++;
      end else if (tok_n == 2) begin
        if (is_digit) x_num = times_ten_plus(x_num, ch);
        else x_is_num = 1'b0;
      end else if (tok_n == 3) begin
        if (is_digit) y_num = times_ten_plus(y_num, ch);
        else y_is_num = 1'b0;
      end
    end
    if (last) begin
      want  = '{1'b0, CmdAdd, '0, '0};
      found = 1'b0;
      if (tok_n >= 1) begin
        for (k = 0; k < NumKw && !found; k++) begin
          kw = keyword_text(cmd_e'(k));
          if (kw_alive[k] && kw_idx == kw.len()) begin
            found     = 1'b1;
            want.code = cmd_e'(k);
          end
        end
      end
      if (found) begin
        if (want.code == CmdList || want.code == CmdKill) begin
          want.valid_res = (tok_n == 1);
        end else if (tok_n == 3 && x_is_num && y_is_num) begin
          want.valid_res = 1'b1;
          want.x_value   = x_num;
          want.y_value   = y_num;
        end
      end
      if (!want.valid_res) want.code = CmdAdd;
      parse_results_due.push_back(want);
      clear_parse();
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    if (rst_n && parse_res.valid && parse_res.ready) begin
      results_checked++;
      if (parse_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result valid_res=%0b cmd=%0d x=%0d y=%0d",
                                  parse_res.valid_res, parse_res.cmd_code,
                                  parse_res.x_value, parse_res.y_value));
      end else begin
        want = parse_results_due.pop_front();
        if (want.valid_res) well_formed_seen++;
        if (parse_res.valid_res !== want.valid_res || parse_res.cmd_code !== want.code ||
            parse_res.x_value !== want.x_value || parse_res.y_value !== want.y_value) begin
          report_mismatch($sformatf(
            "expected valid_res=%0b cmd=%0d x=%0d y=%0d, got valid_res=%0b cmd=%0d x=%0d y=%0d",
            want.valid_res, want.code, want.x_value, want.y_value,
            parse_res.valid_res, parse_res.cmd_code, parse_res.x_value, parse_res.y_value));
        end
      end
    end
    parse_res.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic send_byte(input logic [CharW-1:0] ch, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      msg_bytes.valid <= 1'b0;
      @(posedge clk);
    end
    msg_bytes.valid          <= 1'b1;
    msg_bytes.char_in        <= ch;
    msg_bytes.end_of_message <= last;
    do @(posedge clk); while (!msg_bytes.ready);
    bytes_sent++;
    predict_parse_byte(ch, last);
  endtask

  task automatic send_message(input string text);
    int i;
    for (i = 0; i < text.len(); i++) send_byte(text[i], i == text.len() - 1);
    messages_sent++;
  endtask

  task automatic wait_for_results();
    msg_bytes.valid <= 1'b0;
    @(posedge clk);
    while (parse_results_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic string spaces(input int n);
    string s;
    s = "";
    repeat (n) s = {s, " "};
    return s;
  endfunction

  function automatic logic [CharW-1:0] noise_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 30) return SpaceChar;
    if (pick < 50) return CharW'($urandom_range(DigitLo, DigitHi));
    if (pick < 65) return CharW'($urandom_range("a", "z"));
    return CharW'($urandom_range(1, 255));
  endfunction

  function automatic string number_text();
    string       s;
    int unsigned pick;
    pick = $urandom_range(99);
    s    = "";
    if (pick < 35) s = $sformatf("%0d", $urandom_range(99));
    else if (pick < 60) s = $sformatf("%0d", $urandom_range(32'h7fff_ffff));
    else if (pick < 75) s = $sformatf("%0d", $urandom);
    else if (pick < 88) s = $sformatf("00%0d", $urandom_range(999));
    else repeat ($urandom_range(11, 16)) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  function automatic string well_formed_message();
    cmd_e  op;
    string s;
    int    lead;
    op   = cmd_e'($urandom_range(CmdKill));
    lead = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    s    = {spaces(lead), keyword_text(op)};
    if (op != CmdList && op != CmdKill) begin
      s = {s, spaces($urandom_range(1, 3)), number_text(),
           spaces($urandom_range(1, 3)), number_text()};
    end
    if ($urandom_range(3) == 0) s = {s, spaces($urandom_range(1, 2))};
    return s;
  endfunction

  function automatic string broken_message();
    cmd_e  op;
    string s;
    int    n;
    op = cmd_e'($urandom_range(CmdKill));
    s  = "";
    case ($urandom_range(3))
      0: repeat ($urandom_range(1, 12)) s = {s, $sformatf("%c", noise_byte())};
      1: begin
        s = well_formed_message();
        s.putc($urandom_range(s.len() - 1), noise_byte());
      end
      2: begin
        s = keyword_text(op);
        if (op == CmdList || op == CmdKill) n = $urandom_range(1, 2);
        else n = ($urandom_range(1) == 0) ? $urandom_range(1) : $urandom_range(3, 5);
        repeat (n) s = {s, " ", number_text()};
      end
      default: begin
        s = keyword_text(op);
        if ($urandom_range(1) == 0) s = s.substr(0, s.len() - 2);
        else s = {s, $sformatf("%c", CharW'($urandom_range(33, 255)))};
        if ($urandom_range(1) == 0) s = {s, " ", number_text(), " ", number_text()};
      end
    endcase
    return s;
  endfunction

  task automatic test_well_formed_commands();
    send_message("add 1 2");
    send_message("rm 0 0");
    send_message("query 2147483647 2147483647");
    send_message("list");
    send_message("kill");
    send_message("   add   12    34  ");
    send_message("add 99999999999 2147483648");
    send_message("query 0007 00");
    send_message(" kill ");
    wait_for_results();
  endtask

  task automatic test_malformed_messages();
    send_message(" ");
    send_message("    ");
    send_message("add");
    send_message("rm 5");
    send_message("query 1 2 3");
    send_message("list 1");
    send_message("kill  kill");
    send_message("add 1a 2");
    send_message("rm 3 b");
    send_message("addd 1 2");
    send_message("ad 1 2");
    send_message("querylong 1 2");
    send_message("a b c d e f g h i j");
    send_message($sformatf("add 1 %c", 8'hff));
    send_message("9 9 9");
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int byte_budget);
    int first;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    first              = bytes_sent;
    while (bytes_sent - first < byte_budget) begin
      if ($urandom_range(9) < 7) send_message(well_formed_message());
      else send_message(broken_message());
    end
    wait_for_results();
  endtask

  initial begin
    msg_bytes.valid          = 1'b0;
    msg_bytes.char_in        = '0;
    msg_bytes.end_of_message = 1'b0;
    parse_res.ready          = 1'b0;
    clear_parse();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_well_formed_commands();
    test_malformed_messages();
    test_random_traffic(0, 0, 210);
    test_random_traffic(66, 0, 210);
    test_random_traffic(0, 66, 210);
    test_random_traffic(8, 8, 210);

    $display("Ran %0d messages (%0d bytes); %0d results compared, %0d well formed,",
             messages_sent, bytes_sent, results_checked, well_formed_seen);
    $display("under steady flow, sender gaps, receiver stalls and mixed idling.");
    if (mismatches == 0) begin
      $display("command_message_parser_unit verification clean");
    end else begin
      $display("command_message_parser_unit verification failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d results outstanding", parse_results_due.size());
    $display("command_message_parser_unit verification failed");
    $finish;
  end

endmodule
